@@ sv/hpix_pkg.sv @@
// Types, constants and register codes shared by the hot pixel correction block.
package hpix_pkg;

   localparam int SAMPLE_BITS       = 16;
   localparam int MAX_WIDTH_DEFAULT = 4096;
   localparam int FRAME_WIDTH_BITS  = 13;
   localparam int FRAME_HEIGHT_BITS = 16;
   localparam int ROW_BITS          = FRAME_HEIGHT_BITS + 1;
   localparam int CSR_ADDR_BITS     = 4;
   localparam int CSR_DATA_BITS     = 32;

   localparam logic [FRAME_WIDTH_BITS-1:0]  FRAME_WIDTH_RESET  = 13'd4096;
   localparam logic [FRAME_HEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = 16'd1;
   localparam logic [SAMPLE_BITS-1:0]       LIMIT_RESET        = 16'd19661;

   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   localparam int CH_RED   = 2;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 0;

   localparam int ROW_TOP = 0;
   localparam int ROW_MID = 1;
   localparam int ROW_BOT = 2;

   typedef enum logic [1:0] {
      REG_FRAME_WIDTH,
      REG_FRAME_HEIGHT,
      REG_DEVIATION_LIMIT
   } csr_index_type;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef sample_type [2:0]       pixel_type;
   typedef pixel_type [2:0]        column_type;

   typedef struct packed {
      logic       req_type;
      sample_type in_red;
      sample_type in_green;
      sample_type in_blue;
   } req_beat_type;

   typedef struct packed {
      sample_type out_red;
      sample_type out_green;
      sample_type out_blue;
      logic       end_of_frame;
   } rsp_beat_type;

   typedef struct packed {
      logic top_rep;
      logic bot_rep;
      logic left_rep;
      logic use_new;
   } win_sel_type;

   typedef struct packed {
      logic        emit;
      logic        flush;
      logic        last;
      logic        fwd;
      win_sel_type sel;
   } stage_type;

endpackage

@@ sv/hpix_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module hpix_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/hpix_fix.sv @@
// Neighbour mean and replacement decision for the three channels of one window.
module hpix_fix (
   input  hpix_pkg::column_type  prev_col,
   input  hpix_pkg::column_type  cur_col,
   input  hpix_pkg::column_type  new_col,
   input  hpix_pkg::win_sel_type sel,
   input  hpix_pkg::sample_type  limit,
   output hpix_pkg::pixel_type   fixed
);
   import hpix_pkg::*;

   localparam int SUM9_BITS = SAMPLE_BITS + 4;
   localparam int SUM8_BITS = SAMPLE_BITS + 3;

   column_type left_col;
   column_type right_col;
   logic       bypass;

   assign left_col  = sel.left_rep ? cur_col : prev_col;
   assign right_col = sel.use_new ? new_col : cur_col;
   assign bypass    = (limit == '0);

   for (genvar ch = 0; ch < 3; ch++) begin : g_ch
      sample_type           lt, lm, lb, ct, cm, cb, rt, rm, rb;
      logic [SUM9_BITS-1:0] sum9;
      logic [SUM8_BITS-1:0] sum8;
      sample_type           mean;
      sample_type           dev;

      assign lt = sel.top_rep ? left_col[ROW_MID][ch]  : left_col[ROW_TOP][ch];
      assign lm = left_col[ROW_MID][ch];
      assign lb = sel.bot_rep ? left_col[ROW_MID][ch]  : left_col[ROW_BOT][ch];
      assign ct = sel.top_rep ? cur_col[ROW_MID][ch]   : cur_col[ROW_TOP][ch];
      assign cm = cur_col[ROW_MID][ch];
      assign cb = sel.bot_rep ? cur_col[ROW_MID][ch]   : cur_col[ROW_BOT][ch];
      assign rt = sel.top_rep ? right_col[ROW_MID][ch] : right_col[ROW_TOP][ch];
      assign rm = right_col[ROW_MID][ch];
      assign rb = sel.bot_rep ? right_col[ROW_MID][ch] : right_col[ROW_BOT][ch];

      assign sum9 = SUM9_BITS'(lt) + SUM9_BITS'(lm) + SUM9_BITS'(lb)
                  + SUM9_BITS'(ct) + SUM9_BITS'(cm) + SUM9_BITS'(cb)
                  + SUM9_BITS'(rt) + SUM9_BITS'(rm) + SUM9_BITS'(rb);
      assign sum8 = SUM8_BITS'(sum9 - SUM9_BITS'(cm));
      assign mean = sum8[SUM8_BITS-1:3];
      assign dev  = (cm > mean) ? (cm - mean) : (mean - cm);

      assign fixed[ch] = (!bypass && (dev > limit)) ? mean : cm;
   end

endmodule

@@ sv/hot_pixel_neighbour_mean_replace_core.sv @@
// Top level of the hot pixel correction block: position counters, line store, window, output.
//
//   channel  | direction | ports                       | payload
//   ---------+-----------+-----------------------------+-------------------------------
//   request  | in        | req_valid / req_ready       | req_data  (req_beat_type)
//   response | out       | rsp_valid / rsp_ready       | rsp_data  (rsp_beat_type)
//   csr      | in/out    | csr_psel .. csr_pready      | csr_pwdata / csr_prdata, 32 bit
//
// One beat per cycle in, one result per cycle out unless the response stalls; a pixel leaves
// frame_width + 1 beats after it enters. Stages: line store read and correction, then output.
// The line store is a single RAM, read at acceptance, written when the correction stage moves.
// Reset clears counters, window and valid flags; the line store is not cleared.
// A stalled response holds the correction stage, which in turn lowers req_ready.
module hot_pixel_neighbour_mean_replace_core #(
   parameter int MAX_WIDTH = hpix_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  hpix_pkg::req_beat_type                 req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output hpix_pkg::rsp_beat_type                 rsp_data,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [hpix_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [hpix_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [hpix_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                   csr_pready
);
   import hpix_pkg::*;

   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int WID_BITS  = COL_BITS + 1;
   localparam int PIX_BITS  = $bits(pixel_type);
   localparam int LINE_BITS = 2 * PIX_BITS;

   // configuration
   logic [FRAME_WIDTH_BITS-1:0]  width_ff, width_in;
   logic [FRAME_HEIGHT_BITS-1:0] height_ff, height_in;
   sample_type                   limit_ff, limit_in;
   logic                         csr_write;
   logic                         geom_write;
   csr_index_type                csr_index;

   // position
   logic [COL_BITS-1:0]  column_ff, column_in;
   logic [ROW_BITS-1:0]  row_ff, row_in;
   logic [WID_BITS-1:0]  width_eff;
   logic [ROW_BITS-1:0]  height_eff;
   logic [ROW_BITS-1:0]  height_plus1;
   logic [COL_BITS-1:0]  col_cur;
   logic [WID_BITS-1:0]  col_next;
   logic                 col_wrap;
   logic                 flush_cur;
   logic                 live;
   logic                 req_fire;
   logic                 take;
   logic                 row_start;
   logic                 normal;
   stage_type            flags_cur;

   // correction stage
   logic                 s1_valid_ff, s1_valid_in;
   stage_type            s1_flags_ff;
   logic [COL_BITS-1:0]  s1_col_ff;
   pixel_type            s1_pix_ff;
   pixel_type            fwd_upper_ff, fwd_upper_in;
   pixel_type            fwd_middle_ff, fwd_middle_in;
   logic                 s1_go;
   logic [LINE_BITS-1:0] ram_rd_data;
   pixel_type            upper_eff;
   pixel_type            middle_eff;
   column_type           new_col;
   column_type           win_prev_ff, win_prev_in;
   column_type           win_cur_ff, win_cur_in;
   pixel_type            fixed_pix;

   // output
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_beat_type         rsp_data_ff, rsp_data_in;

   // csr port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[3:2]);
   assign geom_write = csr_write &&
                       ((csr_index == REG_FRAME_WIDTH) || (csr_index == REG_FRAME_HEIGHT));

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      limit_in  = limit_ff;
      if (csr_write) begin
         case (csr_index)
            REG_FRAME_WIDTH:     width_in  = csr_pwdata[FRAME_WIDTH_BITS-1:0];
            REG_FRAME_HEIGHT:    height_in = csr_pwdata[FRAME_HEIGHT_BITS-1:0];
            REG_DEVIATION_LIMIT: limit_in  = csr_pwdata[SAMPLE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_FRAME_WIDTH:     csr_prdata = CSR_DATA_BITS'(width_ff);
         REG_FRAME_HEIGHT:    csr_prdata = CSR_DATA_BITS'(height_ff);
         REG_DEVIATION_LIMIT: csr_prdata = CSR_DATA_BITS'(limit_ff);
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FRAME_WIDTH_RESET;
         height_ff <= FRAME_HEIGHT_RESET;
         limit_ff  <= LIMIT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         limit_ff  <= limit_in;
      end
   end

   // effective geometry
   always_comb begin
      if (width_ff == '0) begin
         width_eff = WID_BITS'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         width_eff = WID_BITS'(MAX_WIDTH);
      end else begin
         width_eff = WID_BITS'(width_ff);
      end
   end

   assign height_eff   = (height_ff == '0) ? ROW_BITS'(1) : ROW_BITS'(height_ff);
   assign height_plus1 = height_eff + ROW_BITS'(1);

   // position decode at acceptance
   assign col_cur   = (WID_BITS'(column_ff) >= width_eff) ? '0 : column_ff;
   assign col_next  = WID_BITS'(col_cur) + WID_BITS'(1);
   assign col_wrap  = (col_next >= width_eff);
   assign flush_cur = (row_ff >= height_eff);
   assign live      = !((req_data.req_type == REQ_DRAIN) && !flush_cur);
   assign req_fire  = req_valid && req_ready;
   assign take      = req_fire && live;

   assign row_start = (col_cur == '0) && (row_ff >= ROW_BITS'(2)) && (row_ff <= height_plus1);
   assign normal    = (col_cur != '0) && (row_ff != '0) && (row_ff <= height_eff);

   always_comb begin
      flags_cur.emit  = row_start || normal;
      flags_cur.flush = flush_cur;
      flags_cur.last  = row_start && (row_ff == height_plus1);
      flags_cur.fwd   = s1_go && !s1_flags_ff.flush && (s1_col_ff == col_cur);
      flags_cur.sel.use_new = normal;
      if (row_start) begin
         flags_cur.sel.top_rep  = (row_ff == ROW_BITS'(2));
         flags_cur.sel.bot_rep  = (row_ff == height_plus1);
         flags_cur.sel.left_rep = (width_eff == WID_BITS'(1));
      end else begin
         flags_cur.sel.top_rep  = (row_ff == ROW_BITS'(1));
         flags_cur.sel.bot_rep  = (row_ff == height_eff);
         flags_cur.sel.left_rep = (col_cur == COL_BITS'(1));
      end
   end

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (geom_write) begin
         column_in = '0;
         row_in    = '0;
      end else if (take) begin
         if (flags_cur.last) begin
            column_in = '0;
            row_in    = '0;
         end else if (col_wrap) begin
            column_in = '0;
            row_in    = row_ff + ROW_BITS'(1);
         end else begin
            column_in = col_next[COL_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

   // line store: upper row in the high half, middle row in the low half
   hpix_ram #(
      .WIDTH (LINE_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_go && !s1_flags_ff.flush),
      .wr_addr (s1_col_ff),
      .wr_data ({middle_eff, s1_pix_ff}),
      .rd_en   (take),
      .rd_addr (col_cur),
      .rd_data (ram_rd_data)
   );

   // correction stage
   assign s1_go     = s1_valid_ff && (!s1_flags_ff.emit || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_go;

   assign upper_eff  = s1_flags_ff.fwd ? fwd_upper_ff  : ram_rd_data[LINE_BITS-1:PIX_BITS];
   assign middle_eff = s1_flags_ff.fwd ? fwd_middle_ff : ram_rd_data[PIX_BITS-1:0];

   assign new_col[ROW_TOP] = upper_eff;
   assign new_col[ROW_MID] = middle_eff;
   assign new_col[ROW_BOT] = s1_flags_ff.flush ? middle_eff : s1_pix_ff;

   assign fwd_upper_in  = middle_eff;
   assign fwd_middle_in = s1_pix_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (take) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_flags_ff   <= flags_cur;
         s1_col_ff     <= col_cur;
         s1_pix_ff     <= {req_data.in_red, req_data.in_green, req_data.in_blue};
         fwd_upper_ff  <= fwd_upper_in;
         fwd_middle_ff <= fwd_middle_in;
      end
   end

   // window: previous and current columns; the incoming column joins combinationally
   always_comb begin
      win_prev_in = win_prev_ff;
      win_cur_in  = win_cur_ff;
      if (s1_go) begin
         win_prev_in = win_cur_ff;
         win_cur_in  = new_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_prev_ff <= '0;
         win_cur_ff  <= '0;
      end else begin
         win_prev_ff <= win_prev_in;
         win_cur_ff  <= win_cur_in;
      end
   end

   hpix_fix u_fix (
      .prev_col (win_prev_ff),
      .cur_col  (win_cur_ff),
      .new_col  (new_col),
      .sel      (s1_flags_ff.sel),
      .limit    (limit_ff),
      .fixed    (fixed_pix)
   );

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s1_go && s1_flags_ff.emit) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.out_red      = fixed_pix[CH_RED];
         rsp_data_in.out_green    = fixed_pix[CH_GREEN];
         rsp_data_in.out_blue     = fixed_pix[CH_BLUE];
         rsp_data_in.end_of_frame = s1_flags_ff.last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ verif/hot_pixel_neighbour_mean_replace_core_tb.sv @@
// Self-checking bench for the hot pixel correction core: directed frames, then random frames.
`timescale 1ns / 100ps

module tb;
   import hpix_pkg::*;

   typedef enum int {TEX_NOISE, TEX_FLAT, TEX_RAIL} texture_type;
   typedef enum int {RX_OPEN, RX_COIN, RX_STINGY, RX_CADENCE} rx_mode_type;

   class defect_fix_scoreboard;
      logic [FRAME_WIDTH_BITS-1:0]  width_reg;
      logic [FRAME_HEIGHT_BITS-1:0] height_reg;
      sample_type                   limit_reg;
      pixel_type                    upper_line [MAX_WIDTH_DEFAULT];
      pixel_type                    middle_line [MAX_WIDTH_DEFAULT];
      pixel_type                    win [3][3];
      int unsigned                  col;
      int unsigned                  row;
      rsp_beat_type                 fixed_q [$];
      int                           errors;
      int                           frames_done;

      function new();
         width_reg   = FRAME_WIDTH_RESET;
         height_reg  = FRAME_HEIGHT_RESET;
         limit_reg   = LIMIT_RESET;
         col         = 0;
         row         = 0;
         errors      = 0;
         frames_done = 0;
         foreach (upper_line[i]) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
         end
         foreach (win[r, c]) win[r][c] = '0;
      endfunction

      function int unsigned eff_width();
         if (width_reg == 0) return 1;
         if (width_reg > MAX_WIDTH_DEFAULT) return MAX_WIDTH_DEFAULT;
         return 32'(width_reg);
      endfunction

      function int unsigned eff_height();
         return (height_reg == 0) ? 1 : 32'(height_reg);
      endfunction

      function bit in_flush();
         return row >= eff_height();
      endfunction

      function int pending();
         return fixed_q.size();
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] v);
         case (idx)
            REG_FRAME_WIDTH: begin
               width_reg = v[FRAME_WIDTH_BITS-1:0];
               col = 0;
               row = 0;
            end
            REG_FRAME_HEIGHT: begin
               height_reg = v[FRAME_HEIGHT_BITS-1:0];
               col = 0;
               row = 0;
            end
            REG_DEVIATION_LIMIT: limit_reg = v[SAMPLE_BITS-1:0];
            default: ;
         endcase
      endfunction

      function logic [CSR_DATA_BITS-1:0] reg_value(csr_index_type idx);
         case (idx)
            REG_FRAME_WIDTH:  return CSR_DATA_BITS'(width_reg);
            REG_FRAME_HEIGHT: return CSR_DATA_BITS'(height_reg);
            default:          return CSR_DATA_BITS'(limit_reg);
         endcase
      endfunction

      // centre sits in window row 1, column c1
      function sample_type fix_channel(int r0, int r2, int c0, int c1, int c2, int ch);
         int unsigned total;
         sample_type  centre;
         sample_type  mean;
         sample_type  dev;
         int          rs [3];
         int          cs [3];
         rs = '{r0, 1, r2};
         cs = '{c0, c1, c2};
         centre = win[1][c1][ch];
         total = 0;
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               total += win[rs[i]][cs[j]][ch];
         total -= centre;
         mean = sample_type'(total >> 3);
         if (limit_reg == 0) return centre;
         dev = (centre > mean) ? centre - mean : mean - centre;
         return (dev > limit_reg) ? mean : centre;
      endfunction

      function void emit_fix(int unsigned px, int unsigned py, int unsigned w, int unsigned h,
                             int cc, int lc, int rc);
         rsp_beat_type res;
         pixel_type    p;
         int           r0;
         int           r2;
         r0 = (py == 0) ? 1 : 0;
         r2 = (py == h - 1) ? 1 : 2;
         for (int ch = 0; ch < 3; ch++) p[ch] = fix_channel(r0, r2, lc, cc, rc, ch);
         res.out_red      = p[CH_RED];
         res.out_green    = p[CH_GREEN];
         res.out_blue     = p[CH_BLUE];
         res.end_of_frame = (px == w - 1 && py == h - 1);
         fixed_q.push_back(res);
      endfunction

      // returns 0 when the beat is ignored
      function bit note_beat(req_beat_type b);
         int unsigned w;
         int unsigned h;
         int unsigned x;
         int unsigned y;
         int unsigned px;
         int unsigned py;
         bit          flush;
         bit          have;
         pixel_type   p;
         w = eff_width();
         h = eff_height();
         flush = row >= h;
         x = col;
         y = row;
         px = 0;
         py = 0;
         have = 0;
         if (b.req_type == REQ_DRAIN && !flush) return 0;
         if (x >= w) x = 0;
         p[CH_RED]   = b.in_red;
         p[CH_GREEN] = b.in_green;
         p[CH_BLUE]  = b.in_blue;
         if (x == 0 && y >= 2 && y - 2 < h) begin
            px = w - 1;
            py = y - 2;
            emit_fix(px, py, w, h, 2, (w == 1) ? 2 : 1, 2);
            have = 1;
         end
         for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
         end
         win[0][2] = upper_line[x];
         win[1][2] = middle_line[x];
         win[2][2] = flush ? middle_line[x] : p;
         if (!flush) begin
            upper_line[x]  = middle_line[x];
            middle_line[x] = p;
         end
         if (x >= 1 && y >= 1 && y - 1 < h) begin
            px = x - 1;
            py = y - 1;
            emit_fix(px, py, w, h, 1, (px == 0) ? 1 : 0, (px == w - 1) ? 1 : 2);
            have = 1;
         end
         if (have && px == w - 1 && py == h - 1) begin
            col = 0;
            row = 0;
            frames_done++;
         end else begin
            x++;
            if (x >= w) begin
               x = 0;
               y++;
            end
            col = x;
            row = y;
         end
         return 1;
      endfunction

      function void check_result(rsp_beat_type got);
         rsp_beat_type want;
         if (fixed_q.size() == 0) begin
            $error("unexpected result beat %h", got);
            errors++;
            return;
         end
         want = fixed_q.pop_front();
         if (got.out_red !== want.out_red) begin
            $error("out_red: expected %h, got %h", want.out_red, got.out_red);
            errors++;
         end
         if (got.out_green !== want.out_green) begin
            $error("out_green: expected %h, got %h", want.out_green, got.out_green);
            errors++;
         end
         if (got.out_blue !== want.out_blue) begin
            $error("out_blue: expected %h, got %h", want.out_blue, got.out_blue);
            errors++;
         end
         if (got.end_of_frame !== want.end_of_frame) begin
            $error("end_of_frame: expected %b, got %b", want.end_of_frame, got.end_of_frame);
            errors++;
         end
      endfunction
   endclass

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_valid   = 1'b0;
   logic                       req_ready;
   req_beat_type               req_data    = '0;
   logic                       rsp_valid;
   logic                       rsp_ready   = 1'b0;
   rsp_beat_type               rsp_data;
   logic                       csr_psel    = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0]   csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0]   csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0]   csr_prdata;
   logic                       csr_pready;

   defect_fix_scoreboard sb = new();
   bit                   tx_up;
   int                   burst_left;
   int                   live_beats;
   pixel_type            flat_level;
   rx_mode_type          rx_mode = RX_OPEN;
   int                   rx_span;
   int unsigned          rx_tick;

   hot_pixel_neighbour_mean_replace_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (rx_span <= 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_span = $urandom_range(20, 200);
      end
      rx_span--;
      rx_tick++;
      case (rx_mode)
         RX_OPEN:    rsp_ready <= 1'b1;
         RX_COIN:    rsp_ready <= 1'($urandom_range(0, 1));
         RX_STINGY:  rsp_ready <= ($urandom_range(0, 7) == 0);
         default:    rsp_ready <= (rx_tick % 5 != 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_data);
   end

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(idx, v);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read_check(input csr_index_type idx);
      logic [CSR_DATA_BITS-1:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (got !== sb.reg_value(idx)) begin
         $error("%s: expected %h, got %h", idx.name(), sb.reg_value(idx), got);
         sb.errors++;
      end
   endtask

   task automatic set_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] v);
      csr_write(idx, v);
      csr_read_check(idx);
   endtask

   task automatic drop_valid();
      if (tx_up) begin
         req_valid <= 1'b0;
         tx_up = 1'b0;
      end
   endtask

   task automatic push_beat(input req_beat_type b);
      if (!tx_up) begin
         req_valid <= 1'b1;
         tx_up = 1'b1;
      end
      req_data <= b;
      do @(posedge clock); while (!req_ready);
      if (sb.note_beat(b)) live_beats++;
   endtask

   task automatic pace();
      int gap;
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 12);
         gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            drop_valid();
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // hold off until every expected beat is back, then let the pipeline empty
   task automatic settle();
      drop_valid();
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic req_beat_type pix(sample_type r, sample_type g, sample_type b);
      req_beat_type beat;
      beat.req_type = REQ_PIXEL;
      beat.in_red   = r;
      beat.in_green = g;
      beat.in_blue  = b;
      return beat;
   endfunction

   function automatic req_beat_type tick();
      req_beat_type beat;
      beat = pix(16'($urandom), 16'($urandom), 16'($urandom));
      beat.req_type = REQ_DRAIN;
      return beat;
   endfunction

   function automatic req_beat_type make_beat(texture_type tex);
      pixel_type p;
      int        lvl;
      for (int ch = 0; ch < 3; ch++) begin
         case (tex)
            TEX_NOISE: p[ch] = 16'($urandom);
            TEX_RAIL:  p[ch] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: begin
               lvl = int'(flat_level[ch]) + int'($urandom_range(0, 800)) - 400;
               if ($urandom_range(0, 11) == 0) p[ch] = 16'($urandom);
               else if (lvl < 0) p[ch] = 16'h0000;
               else if (lvl > 65535) p[ch] = 16'hFFFF;
               else p[ch] = 16'(lvl);
            end
         endcase
      end
      return pix(p[CH_RED], p[CH_GREEN], p[CH_BLUE]);
   endfunction

   // well-formed frames with a sprinkling of misplaced drains and pixels
   task automatic stream(input int frames, input int cut, input texture_type tex,
                         input int noise_pct);
      int           target;
      int           sent;
      bit           fl;
      req_beat_type b;
      target = sb.frames_done + frames;
      sent = 0;
      for (int ch = 0; ch < 3; ch++) flat_level[ch] = 16'($urandom);
      while (sb.frames_done < target && (cut == 0 || sent < cut)) begin
         fl = sb.in_flush();
         b = make_beat(tex);
         if ($urandom_range(0, 99) < noise_pct) b.req_type = fl ? REQ_PIXEL : REQ_DRAIN;
         else b.req_type = fl ? REQ_DRAIN : REQ_PIXEL;
         push_beat(b);
         sent++;
         if ($urandom_range(0, 199) == 0) settle();
         pace();
      end
   endtask

   task automatic small_frame();
      for (int i = 0; i < 9; i++) begin
         case (i)
            4:       push_beat(pix(16'hFFFF, 16'hFFFF, 16'hFFFF));
            8:       push_beat(pix(16'd8, 16'd9, 16'd7));
            default: push_beat(pix(16'h0000, 16'h0000, 16'h0000));
         endcase
         if (i == 2) push_beat(tick());
         pace();
      end
      push_beat(pix(16'h1234, 16'hABCD, 16'h5A5A));
      repeat (3) begin
         push_beat(tick());
         pace();
      end
   endtask

   task automatic random_phase(input bit regeometry);
      int          w;
      int          h;
      int          pick;
      int          cut;
      texture_type tex;
      case ($urandom_range(0, 19))
         0:        w = 0;
         1, 2, 3:  w = $urandom_range(7, 40);
         default:  w = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 19))
         0:        h = 0;
         1, 2:     h = $urandom_range(6, 12);
         default:  h = $urandom_range(1, 5);
      endcase
      pick = $urandom_range(0, 9);
      if (regeometry || pick < 5) begin
         if ($urandom_range(0, 1)) begin
            set_reg(REG_FRAME_WIDTH, w);
            set_reg(REG_FRAME_HEIGHT, h);
         end else begin
            set_reg(REG_FRAME_HEIGHT, h);
            set_reg(REG_FRAME_WIDTH, w);
         end
      end else if (pick < 7) set_reg(REG_FRAME_WIDTH, w);
      else if (pick < 8) set_reg(REG_FRAME_HEIGHT, h);
      if ($urandom_range(0, 9) < 6) begin
         case ($urandom_range(0, 5))
            0:       set_reg(REG_DEVIATION_LIMIT, 0);
            1:       set_reg(REG_DEVIATION_LIMIT, 1);
            2:       set_reg(REG_DEVIATION_LIMIT, 16'hFFFF);
            3:       set_reg(REG_DEVIATION_LIMIT, $urandom_range(0, 65535));
            default: set_reg(REG_DEVIATION_LIMIT, $urandom_range(2, 3000));
         endcase
      end
      w = sb.eff_width();
      h = sb.eff_height();
      cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, (w + 1) * (h + 1) + 4) : 0;
      tex = texture_type'($urandom_range(0, 2));
      stream($urandom_range(1, 3), cut, tex, $urandom_range(0, 8));
      settle();
   endtask

   initial begin
      bit first;
      tx_up = 1'b0;
      burst_left = 0;
      live_beats = 0;
      rx_span = 0;
      rx_tick = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_read_check(REG_FRAME_WIDTH);
      csr_read_check(REG_FRAME_HEIGHT);
      csr_read_check(REG_DEVIATION_LIMIT);

      // oversize width clamps to the full line; abandon the frame early
      set_reg(REG_FRAME_WIDTH, 32'h1FFF);
      set_reg(REG_FRAME_HEIGHT, 2);
      push_beat(tick());
      stream(1, 60, TEX_FLAT, 0);
      settle();

      set_reg(REG_FRAME_WIDTH, 0);
      set_reg(REG_FRAME_HEIGHT, 0);
      set_reg(REG_DEVIATION_LIMIT, 16'hFFFF);
      push_beat(pix(16'hFFFF, 16'h0000, 16'h8000));
      push_beat(tick());
      push_beat(tick());
      settle();

      set_reg(REG_FRAME_WIDTH, 3);
      set_reg(REG_FRAME_HEIGHT, 3);
      set_reg(REG_DEVIATION_LIMIT, 1);
      small_frame();
      settle();
      set_reg(REG_DEVIATION_LIMIT, 0);
      small_frame();
      settle();

      // tallest frame, abandoned part-way
      set_reg(REG_FRAME_WIDTH, 2);
      set_reg(REG_FRAME_HEIGHT, 16'hFFFF);
      stream(1, 40, TEX_NOISE, 3);
      settle();

      live_beats = 0;
      first = 1'b1;
      while (live_beats < 400) begin
         random_phase(first);
         first = 1'b0;
      end
      settle();
      if (sb.errors == 0 && sb.pending() == 0)
         $display("hot_pixel_neighbour_mean_replace_core test passed");
      else
         $display("hot_pixel_neighbour_mean_replace_core test failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("hot_pixel_neighbour_mean_replace_core test failed");
      $finish;
   end

endmodule
